FILE: hdl/rtfp_pkg.sv
package rtfp_pkg;

  localparam int unsigned BodyBytes = 24;
  localparam int unsigned SlotBytes = 8;
  localparam int unsigned CountW    = 5;
  localparam int unsigned SlotW     = 2;

  localparam logic [7:0] Hdr0Byte  = 8'hAA;
  localparam logic [7:0] Hdr1Byte  = 8'hFF;
  localparam logic [7:0] Hdr2Byte  = 8'h03;
  localparam logic [7:0] Hdr3Byte  = 8'h00;
  localparam logic [7:0] Tail0Byte = 8'h55;
  localparam logic [7:0] Tail1Byte = 8'hCC;

  localparam logic [CountW-1:0] TailCount = CountW'(BodyBytes);
  localparam logic [CountW-1:0] LastCount = CountW'(BodyBytes + 1);

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_HDR2 = 5'b00100,
    PH_HDR3 = 5'b01000,
    PH_BODY = 5'b10000
  } phase_e;

  typedef logic [BodyBytes-1:0][7:0] frame_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [SlotW-1:0]   target_index;
    logic               detected;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] velocity;
    logic [15:0]        pixel_distance;
    logic               last_target;
  } target_t;

  // Bit 15 set means positive; otherwise the low 15 bits are negated.
  function automatic logic signed [15:0] sign_mag(input logic [15:0] raw);
    logic [15:0] mag;
    mag = {1'b0, raw[14:0]};
    return raw[15] ? mag : 16'(-mag);
  endfunction

endpackage

FILE: hdl/rtfp_stream_if.sv
interface rtfp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/radar_target_frame_parser.sv
// Accepts one received byte per cycle unless stalled. A good frame's targets
// are buffered on its last tail byte, then registered out one per cycle while
// the sink takes them. The input stalls only when a frame's last tail byte
// arrives while the previous frame's targets are still queued in the single
// result buffer. Reset (asynchronous, active low) returns the hunt to the
// first header byte and empties the result buffer.
module radar_target_frame_parser #(
  parameter int unsigned TARGET_SLOTS = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rtfp_stream_if.sink   rx_i,
  rtfp_stream_if.source tgt_o
);
  import rtfp_pkg::*;

  logic   load;
  logic   busy;
  frame_t frame;

  rtfp_sync u_sync (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_i.valid),
    .byte_i  (rx_i.payload.rx_byte),
    .ready_o (rx_i.ready),
    .busy_i  (busy),
    .load_o  (load),
    .frame_o (frame)
  );

  rtfp_emit #(
    .TARGET_SLOTS (TARGET_SLOTS)
  ) u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .frame_i  (frame),
    .busy_o   (busy),
    .valid_o  (tgt_o.valid),
    .ready_i  (tgt_o.ready),
    .target_o (tgt_o.payload)
  );

  a_last_matches_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tgt_o.valid |-> (tgt_o.payload.last_target ==
                     (tgt_o.payload.target_index == SlotW'(TARGET_SLOTS - 1))))
    else $error("last_target does not match the final slot");

  a_stall_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> busy)
    else $error("input stalled while the result buffer is empty");

  a_slots_consecutive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tgt_o.valid && tgt_o.ready && !tgt_o.payload.last_target) |=>
      (tgt_o.valid &&
       tgt_o.payload.target_index == $past(tgt_o.payload.target_index) + 1'b1))
    else $error("target slots of a frame are not delivered back to back");

endmodule

FILE: hdl/rtfp_sync.sv
module rtfp_sync (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [7:0]      byte_i,
  output logic            ready_o,
  input  logic            busy_i,
  output logic            load_o,
  output rtfp_pkg::frame_t frame_o
);
  import rtfp_pkg::*;

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   count_q, count_d;
  frame_t              store_q;
  logic [7:0]          tail_q;
  logic                accept;
  logic                wr_en;
  logic                tail_en;

  // A frame can only complete on the second tail byte, so only that byte waits
  // for the emitter to free its buffer.
  assign ready_o = !(phase_q == PH_BODY && count_q == LastCount && busy_i);
  assign accept  = valid_i && ready_o;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    load_o  = 1'b0;
    wr_en   = 1'b0;
    tail_en = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_HDR0: phase_d = (byte_i == Hdr0Byte) ? PH_HDR1 : PH_HDR0;
        PH_HDR1: phase_d = (byte_i == Hdr1Byte) ? PH_HDR2 : PH_HDR0;
        PH_HDR2: phase_d = (byte_i == Hdr2Byte) ? PH_HDR3 : PH_HDR0;
        PH_HDR3: begin
          if (byte_i == Hdr3Byte) begin
            phase_d = PH_BODY;
            count_d = '0;
          end else begin
            phase_d = PH_HDR0;
          end
        end
        PH_BODY: begin
          if (count_q < TailCount) begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
          end else if (count_q == TailCount) begin
            tail_en = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            load_o  = (tail_q == Tail0Byte) && (byte_i == Tail1Byte);
            phase_d = PH_HDR0;
            count_d = '0;
          end
        end
        default: phase_d = PH_HDR0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[count_q] <= byte_i;
    end
    if (tail_en) begin
      tail_q <= byte_i;
    end
  end

  assign frame_o = store_q;

endmodule

FILE: hdl/rtfp_emit.sv
module rtfp_emit #(
  parameter int unsigned TARGET_SLOTS = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rtfp_pkg::frame_t  frame_i,
  output logic              busy_o,
  output logic              valid_o,
  input  logic              ready_i,
  output rtfp_pkg::target_t target_o
);
  import rtfp_pkg::*;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(TARGET_SLOTS - 1);

  logic [TARGET_SLOTS-1:0][63:0] buf_q;
  logic                          pend_q;
  logic [SlotW-1:0]              slot_q;
  logic                          valid_q;
  target_t                       out_q, out_d;
  logic [63:0]                   sel;
  logic                          adv;

  assign adv    = pend_q && (!valid_q || ready_i);
  assign busy_o = pend_q;

  always_comb begin
    sel = '0;
    for (int s = 0; s < TARGET_SLOTS; s++) begin
      if (slot_q == SlotW'(s)) begin
        sel = buf_q[s];
      end
    end
    out_d.target_index   = slot_q;
    out_d.detected       = |sel;
    out_d.x_pos          = sign_mag(sel[15:0]);
    out_d.y_pos          = sign_mag(sel[31:16]);
    out_d.velocity       = sign_mag(sel[47:32]);
    out_d.pixel_distance = sel[63:48];
    out_d.last_target    = (slot_q == LastSlot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      slot_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        pend_q <= 1'b1;
        slot_q <= '0;
      end else if (adv) begin
        if (slot_q == LastSlot) begin
          pend_q <= 1'b0;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
      if (adv) begin
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int s = 0; s < TARGET_SLOTS; s++) begin
        buf_q[s] <= frame_i[s*SlotBytes +: SlotBytes];
      end
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign valid_o  = valid_q;
  assign target_o = out_q;

endmodule
